// ----- rtl/core/queue_with_front_insert_and_delete_top_macros.svh -----
// ----------------------------------------------------------------------------
// queue with front insert and delete: assertion macros
// Shared property wrappers for the checker of the queue block.
// ----------------------------------------------------------------------------
`ifndef QUEUE_WITH_FRONT_INSERT_AND_DELETE_TOP_MACROS_SVH
`define QUEUE_WITH_FRONT_INSERT_AND_DELETE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define QFID_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// next-cycle implication, disabled during reset
`define QFID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- rtl/core/qfid_pkg.sv -----
// ----------------------------------------------------------------------------
// qfid_pkg
// Types and constants shared by the queue cells, top level and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package qfid_pkg;

   // queue geometry
   localparam int DEPTH   = 16;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 5;
   localparam int OCC_W   = 5;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

   typedef logic signed [VALUE_W-1:0] value_type;

   // command codes
   typedef enum logic [1:0] {
      KIND_PUSH        = 2'd0,
      KIND_POP         = 2'd1,
      KIND_INSERT_HEAD = 2'd2,
      KIND_DELETE      = 2'd3
   } kind_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_EMPTY_OR_BAD = 2'd1,
      ST_FULL         = 2'd2
   } status_type;

   // per-cell update select
   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_LOAD = 2'd1,
      CELL_NEXT = 2'd2,
      CELL_PREV = 2'd3
   } cell_op_type;

   typedef struct packed {
      kind_type           kind;
      value_type          value;
      logic [POS_W-1:0]   position;
   } req_type;

   typedef struct packed {
      value_type          popped_value;
      status_type         status;
      logic [OCC_W-1:0]   occupancy;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/queue_with_front_insert_and_delete_top.sv -----
// ----------------------------------------------------------------------------
// queue_with_front_insert_and_delete_top
// Bounded queue with tail push, head pop, head insert and positional delete.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command beat (kind, value, position); it is taken at a
//   rising edge with req_valid high and req_stall low.
//   rsp_* returns exactly one result beat per command (popped value, status,
//   occupancy after the command), taken with rsp_valid high and rsp_stall low.
//   The result is registered and appears the cycle after the command.
//   Throughput is one command per cycle when not stalled. Every slot of the
//   cell row shifts, loads or holds in the same cycle, and one output register
//   holds the result, so any command finishes in a single update of the row.
//   When the receiver stalls a waiting result, req_stall rises and no new
//   command is taken until that result is taken; the result holds steady.
//   Reset (synchronous, active high) empties the queue and drops any waiting
//   result; slot contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
`default_nettype none

module queue_with_front_insert_and_delete_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire qfid_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output qfid_pkg::rsp_type       rsp_data
);

   localparam int CW    = qfid_pkg::COUNT_W;
   localparam int CMPW  = qfid_pkg::CMP_W;
   localparam int DEPTH = qfid_pkg::DEPTH;

   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   qfid_pkg::rsp_type    rsp_data_ff;
   qfid_pkg::rsp_type    rsp_data_in;
   qfid_pkg::rsp_type    result;
   qfid_pkg::value_type  cell_value [DEPTH];
   logic                 accept;
   logic                 full;
   logic                 empty;
   logic                 pos_ok;

   // handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // queue status
   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);
   assign pos_ok = (req_data.position != '0) &&
                   (CMPW'(req_data.position) <= CMPW'(count_ff));

   // result and next count
   always_comb begin
      result.popped_value = '0;
      result.status       = qfid_pkg::ST_OK;
      count_in            = count_ff;
      unique case (req_data.kind)
         qfid_pkg::KIND_PUSH, qfid_pkg::KIND_INSERT_HEAD: begin
            if (full) begin
               result.status = qfid_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         qfid_pkg::KIND_POP: begin
            if (empty) begin
               result.status = qfid_pkg::ST_EMPTY_OR_BAD;
            end else begin
               result.popped_value = cell_value[0];
               count_in            = count_ff - CW'(1);
            end
         end
         qfid_pkg::KIND_DELETE: begin
            if (!pos_ok) begin
               result.status = qfid_pkg::ST_EMPTY_OR_BAD;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
      endcase
      result.occupancy = qfid_pkg::OCC_W'(count_in);
   end

   // output register control
   always_comb begin
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = accept ? result : rsp_data_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // row of queue cells, slot 0 is the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      qfid_pkg::cell_op_type op;
      qfid_pkg::value_type   prev_value;
      qfid_pkg::value_type   next_value;

      // neighbor taps, zero at the ends of the row
      if (i == 0) begin : g_head
         assign prev_value = '0;
      end else begin : g_prev
         assign prev_value = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign next_value = '0;
      end else begin : g_next
         assign next_value = cell_value[i+1];
      end

      // per-slot move decision
      always_comb begin
         op = qfid_pkg::CELL_HOLD;
         if (accept) begin
            unique case (req_data.kind)
               qfid_pkg::KIND_PUSH: begin
                  if (!full && (count_ff == CW'(i))) begin
                     op = qfid_pkg::CELL_LOAD;
                  end
               end
               qfid_pkg::KIND_POP: begin
                  if (!empty && (i < DEPTH - 1)) begin
                     op = qfid_pkg::CELL_NEXT;
                  end
               end
               qfid_pkg::KIND_INSERT_HEAD: begin
                  if (!full) begin
                     op = (i == 0) ? qfid_pkg::CELL_LOAD : qfid_pkg::CELL_PREV;
                  end
               end
               qfid_pkg::KIND_DELETE: begin
                  // slots at and behind the deleted one close the gap
                  if (pos_ok && (i < DEPTH - 1) &&
                      (CMPW'(i + 1) >= CMPW'(req_data.position))) begin
                     op = qfid_pkg::CELL_NEXT;
                  end
               end
            endcase
         end
      end

      qfid_cell u_cell (
         .clock      (clock),
         .op_in      (op),
         .load_value (req_data.value),
         .prev_value (prev_value),
         .next_value (next_value),
         .value_out  (cell_value[i])
      );
   end

endmodule

`default_nettype wire

// ----- rtl/core/qfid_cell.sv -----
// ----------------------------------------------------------------------------
// qfid_cell
// One queue slot: holds, loads a new value, or takes a neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module qfid_cell (
   input  wire logic                  clock,
   input  wire qfid_pkg::cell_op_type op_in,
   input  wire qfid_pkg::value_type   load_value,
   input  wire qfid_pkg::value_type   prev_value,
   input  wire qfid_pkg::value_type   next_value,
   output qfid_pkg::value_type        value_out
);

   qfid_pkg::value_type value_ff;
   qfid_pkg::value_type value_in;

   // slot update select
   always_comb begin
      unique case (op_in)
         qfid_pkg::CELL_HOLD: value_in = value_ff;
         qfid_pkg::CELL_LOAD: value_in = load_value;
         qfid_pkg::CELL_NEXT: value_in = next_value;
         qfid_pkg::CELL_PREV: value_in = prev_value;
      endcase
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

`default_nettype wire

// ----- rtl/core/qfid_checker.sv -----
// ----------------------------------------------------------------------------
// qfid_checker
// Port-level checks on the queue top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "queue_with_front_insert_and_delete_top_macros.svh"

module qfid_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire qfid_pkg::req_type  req_data,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire qfid_pkg::rsp_type  rsp_data
);

   // a stalled result beat stays put
   `QFID_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // input is only held off by a waiting result
   `QFID_ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // a refusal for full only happens at full occupancy
   `QFID_ASSERT_IMPL(a_full_occ, clock, reset, rsp_valid && (rsp_data.status == qfid_pkg::ST_FULL), rsp_data.occupancy == qfid_pkg::OCC_W'(qfid_pkg::DEPTH))

   // a nonzero popped value comes only with an ok status
   `QFID_ASSERT_IMPL(a_pop_ok, clock, reset, rsp_valid && (rsp_data.popped_value != '0), rsp_data.status == qfid_pkg::ST_OK)

endmodule

bind queue_with_front_insert_and_delete_top qfid_checker u_qfid_checker (.*);

`default_nettype wire

// ----- verif/queue_with_front_insert_and_delete_top_tb.sv -----
// ----------------------------------------------------------------------------
// queue_with_front_insert_and_delete_top_tb
// Drives tail push, head pop, head insert and positional delete commands into
// the queue and checks every result beat against a shadow queue kept in the
// bench. Commands come in bursts with random gaps, and the result side stalls
// on its own changing pattern. A short directed run covers the empty and
// bad-position cases. Random phases that lean toward filling or draining
// follow it.
// ----------------------------------------------------------------------------
`default_nettype none

module queue_with_front_insert_and_delete_top_tb;

   localparam int CLK_HALF    = 2;
   localparam int RESET_LEN   = 7;
   localparam int RAND_ITEMS  = 950;
   localparam int DRAIN_WAIT  = 8;
   localparam int CYCLE_LIMIT = 200000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   qfid_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   qfid_pkg::rsp_type rsp_data;

   // commands waiting to be driven, results waiting to arrive
   qfid_pkg::req_type pending_cmds[$];
   qfid_pkg::rsp_type expected_rsps[$];

   // shadow copy of the queue contents
   qfid_pkg::value_type shadow_cells[qfid_pkg::DEPTH];
   int                  shadow_count = 0;

   // generator-side occupancy, used to aim delete positions
   int gen_count = 0;

   int total_cmds    = 0;
   int accepted_cmds = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   // sender burst and gap state
   int  burst_left = 1;
   int  gap_left   = 0;
   bit  holding;

   // receiver stall pattern state
   int  stall_mode = 0;
   int  stall_left = 0;

   queue_with_front_insert_and_delete_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // apply one command to the shadow queue and return the result it gives
   function automatic qfid_pkg::rsp_type apply_queue_command(qfid_pkg::req_type cmd);
      qfid_pkg::rsp_type res;
      int                idx;
      res = '0;
      res.status = qfid_pkg::ST_OK;
      case (cmd.kind)
         qfid_pkg::KIND_PUSH: begin
            if (shadow_count >= qfid_pkg::DEPTH) begin
               res.status = qfid_pkg::ST_FULL;
            end else begin
               shadow_cells[shadow_count] = cmd.value;
               shadow_count++;
            end
         end
         qfid_pkg::KIND_POP: begin
            if (shadow_count == 0) begin
               res.status = qfid_pkg::ST_EMPTY_OR_BAD;
            end else begin
               res.popped_value = shadow_cells[0];
               for (idx = 0; idx < shadow_count - 1; idx++)
                  shadow_cells[idx] = shadow_cells[idx + 1];
               shadow_count--;
            end
         end
         qfid_pkg::KIND_INSERT_HEAD: begin
            if (shadow_count >= qfid_pkg::DEPTH) begin
               res.status = qfid_pkg::ST_FULL;
            end else begin
               for (idx = shadow_count; idx > 0; idx--)
                  shadow_cells[idx] = shadow_cells[idx - 1];
               shadow_cells[0] = cmd.value;
               shadow_count++;
            end
         end
         default: begin
            if (cmd.position < 1 || int'(cmd.position) > shadow_count) begin
               res.status = qfid_pkg::ST_EMPTY_OR_BAD;
            end else begin
               for (idx = int'(cmd.position) - 1; idx < shadow_count - 1; idx++)
                  shadow_cells[idx] = shadow_cells[idx + 1];
               shadow_count--;
            end
         end
      endcase
      res.occupancy = shadow_count[qfid_pkg::OCC_W-1:0];
      return res;
   endfunction

   // queue one command and track how full it leaves the queue
   task automatic add_command(qfid_pkg::kind_type kind, qfid_pkg::value_type value,
                              int pos);
      qfid_pkg::req_type cmd;
      cmd.kind     = kind;
      cmd.value    = value;
      cmd.position = pos[qfid_pkg::POS_W-1:0];
      pending_cmds.push_back(cmd);
      total_cmds++;
      case (kind)
         qfid_pkg::KIND_PUSH, qfid_pkg::KIND_INSERT_HEAD:
            if (gen_count < qfid_pkg::DEPTH) gen_count++;
         qfid_pkg::KIND_POP:
            if (gen_count > 0) gen_count--;
         default: if (pos >= 1 && pos <= gen_count) gen_count--;
      endcase
   endtask

   // random value, with the extremes mixed in
   function automatic qfid_pkg::value_type pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return qfid_pkg::value_type'($urandom);
      endcase
   endfunction

   // stimulus: directed corners, then biased random phases
   initial begin
      int                 n;
      int                 phase_left;
      int                 bias;
      int                 roll;
      int                 pos;
      qfid_pkg::kind_type kind;

      // empty queue corners
      add_command(qfid_pkg::KIND_POP, 32'sd5, 31);
      add_command(qfid_pkg::KIND_DELETE, 32'sh7fff_ffff, 1);
      add_command(qfid_pkg::KIND_DELETE, 32'sh8000_0000, 0);
      // value extremes through both write paths
      add_command(qfid_pkg::KIND_PUSH, 32'sh7fff_ffff, 16);
      add_command(qfid_pkg::KIND_INSERT_HEAD, 32'sh8000_0000, 0);
      add_command(qfid_pkg::KIND_PUSH, '0, 31);
      add_command(qfid_pkg::KIND_INSERT_HEAD, -32'sd1, 15);
      // bad delete positions, then tail, head and middle deletes
      add_command(qfid_pkg::KIND_DELETE, 32'sd0, 0);
      add_command(qfid_pkg::KIND_DELETE, 32'sd0, 5);
      add_command(qfid_pkg::KIND_DELETE, -32'sd1, 31);
      add_command(qfid_pkg::KIND_DELETE, 32'sd0, 4);
      add_command(qfid_pkg::KIND_DELETE, 32'sd0, 1);
      add_command(qfid_pkg::KIND_PUSH, 32'sd123456, 0);
      add_command(qfid_pkg::KIND_DELETE, 32'sd0, 2);
      add_command(qfid_pkg::KIND_POP, 32'sh7fff_ffff, 0);
      add_command(qfid_pkg::KIND_POP, 32'sd0, 0);
      add_command(qfid_pkg::KIND_POP, 32'sd0, 16);

      // random phases that lean toward filling, draining or neither
      phase_left = 0;
      bias = 0;
      for (n = 0; n < RAND_ITEMS; n++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 60);
            bias = $urandom_range(0, 2);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         case (bias)
            0: kind = (roll < 35) ? qfid_pkg::KIND_PUSH :
                      (roll < 70) ? qfid_pkg::KIND_INSERT_HEAD :
                      (roll < 85) ? qfid_pkg::KIND_POP : qfid_pkg::KIND_DELETE;
            1: kind = (roll < 15) ? qfid_pkg::KIND_PUSH :
                      (roll < 30) ? qfid_pkg::KIND_INSERT_HEAD :
                      (roll < 65) ? qfid_pkg::KIND_POP : qfid_pkg::KIND_DELETE;
            default: kind = (roll < 25) ? qfid_pkg::KIND_PUSH :
                            (roll < 50) ? qfid_pkg::KIND_INSERT_HEAD :
                            (roll < 75) ? qfid_pkg::KIND_POP : qfid_pkg::KIND_DELETE;
         endcase
         if (kind == qfid_pkg::KIND_DELETE && gen_count > 0 && $urandom_range(0, 9) != 0)
            pos = $urandom_range(1, gen_count);
         else
            pos = $urandom_range(0, 31);
         add_command(kind, pick_value(), pos);
      end

      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;

      // all commands taken, all results back, then let the pipe settle
      wait (accepted_cmds == total_cmds);
      wait (expected_rsps.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // driver: bursts of command beats separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         holding = req_valid && req_stall;
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(apply_queue_command(req_data));
            void'(pending_cmds.pop_front());
            accepted_cmds++;
         end
         if (holding) begin
            // stalled beat stays as it is
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_cmds[0];
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: free-running, random or mostly-stalled stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_left = $urandom_range(10, 60);
         stall_mode = $urandom_range(0, 2);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= (cycle_count % 4) != 0;
      endcase
   end

   // monitor: compare each result beat with the oldest expectation
   always @(posedge clock) begin
      qfid_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: result beat with nothing expected, expected none, got %p",
                     $time, rsp_data);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.popped_value !== want.popped_value) begin
               $display("%0t: popped_value expected %0d, got %0d",
                        $time, want.popped_value, rsp_data.popped_value);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %s, got %0d",
                        $time, want.status.name(), rsp_data.status);
               error_count++;
            end
            if (rsp_data.occupancy !== want.occupancy) begin
               $display("%0t: occupancy expected %0d, got %0d",
                        $time, want.occupancy, rsp_data.occupancy);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule

`default_nettype wire
